/* sv/sitda_pkg.sv */
// Shared types and constants for the signed integer to decimal ASCII block.
// No dependencies; compile first.
package sitda_pkg;

  localparam int VALUE_W     = 32;                 // input integer width
  localparam int CHAR_W      = 8;                  // ASCII character width
  localparam int DIGITS      = 10;                 // decimal digits of a 32-bit magnitude
  localparam int DIGIT_W     = 4;                  // one BCD digit
  localparam int STEP_W      = $clog2(VALUE_W);    // shift step counter
  localparam int IDX_W       = $clog2(DIGITS);     // digit index
  localparam int QUEUE_DEPTH = 2;                  // default job queue depth

  localparam logic [CHAR_W-1:0]  ASCII_ZERO  = 8'd48;
  localparam logic [CHAR_W-1:0]  ASCII_MINUS = 8'd45;
  localparam logic [DIGIT_W-1:0] BCD_ADJ_MIN = 4'd5;
  localparam logic [DIGIT_W-1:0] BCD_ADJ     = 4'd3;

  // One classified number: sign flag and unsigned magnitude.
  typedef struct packed {
    logic               neg;
    logic [VALUE_W-1:0] mag;
  } job_t;

endpackage

/* sv/sitda_if.sv */
// Valid/ready channel interfaces for the integer input and the character output.
// Depends on sitda_pkg.
interface sitda_in_if;
  import sitda_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface sitda_out_if;
  import sitda_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              is_last;

  modport source (output valid, output char_code, output is_last, input ready);
  modport sink   (input valid, input char_code, input is_last, output ready);
endinterface

/* sv/sitda_front.sv */
// Front end: accept an integer beat, split it into sign and unsigned magnitude.
// Depends on sitda_pkg and sitda_if.
module sitda_front (
  input  logic              clk,
  input  logic              rst_n,
  sitda_in_if.sink          in_ch,
  output logic              push_valid,
  input  logic              push_ready,
  output sitda_pkg::job_t   push_job
);
  import sitda_pkg::*;

  logic stg_valid_r, stg_valid_nxt;
  job_t stg_r, stg_nxt;
  logic [VALUE_W-1:0] raw;

  assign raw         = VALUE_W'(in_ch.value);
  assign in_ch.ready = !stg_valid_r || push_ready;
  assign push_valid  = stg_valid_r;
  assign push_job    = stg_r;

  always_comb begin
    stg_valid_nxt = stg_valid_r;
    stg_nxt       = stg_r;
    if (push_ready) stg_valid_nxt = 1'b0;
    if (in_ch.valid && in_ch.ready) begin
      stg_valid_nxt = 1'b1;
      stg_nxt.neg   = raw[VALUE_W-1];
      // two's complement negate; the most negative value maps onto itself as unsigned
      stg_nxt.mag   = raw[VALUE_W-1] ? (~raw + VALUE_W'(1)) : raw;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else begin
      stg_valid_r <= stg_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    stg_r <= stg_nxt;
  end

endmodule

/* sv/sitda_queue.sv */
// Short job queue between front and back ends.
// Depends on sitda_pkg.
module sitda_queue #(
  parameter int DEPTH = sitda_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_ready,
  input  sitda_pkg::job_t push_job,
  output logic            pop_valid,
  input  logic            pop_ready,
  output sitda_pkg::job_t pop_job
);
  import sitda_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_job    = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    if (do_pop)  rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    if (do_push && !do_pop)      count_nxt = count_r + CNT_W'(1);
    else if (do_pop && !do_push) count_nxt = count_r - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= push_job;
  end

endmodule

/* sv/sitda_back.sv */
// Back end: shift-add-3 binary to BCD, then emit sign and digits as ASCII beats.
// Depends on sitda_pkg and sitda_if.
module sitda_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            pop_valid,
  output logic            pop_ready,
  input  sitda_pkg::job_t pop_job,
  sitda_out_if.source     out_ch
);
  import sitda_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CONV  = 3'd1;
  localparam logic [2:0] ST_LEAD  = 3'd2;
  localparam logic [2:0] ST_SIGN  = 3'd3;
  localparam logic [2:0] ST_DIGIT = 3'd4;

  logic [2:0]                      state_r, state_nxt;
  logic                            neg_r, neg_nxt;
  logic [VALUE_W-1:0]              bin_r, bin_nxt;
  logic [DIGITS-1:0][DIGIT_W-1:0]  bcd_r, bcd_nxt;
  logic [DIGITS-1:0][DIGIT_W-1:0]  bcd_adj;
  logic [STEP_W-1:0]               cnt_r, cnt_nxt;
  logic [IDX_W-1:0]                idx_r, idx_nxt;
  logic [IDX_W-1:0]                lead;
  logic                            out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]               out_char_r, out_char_nxt;
  logic                            out_last_r, out_last_nxt;
  logic                            out_free;
  logic                            take;

  assign out_ch.valid     = out_valid_r;
  assign out_ch.char_code = out_char_r;
  assign out_ch.is_last   = out_last_r;
  assign out_free         = !out_valid_r || out_ch.ready;

  // add 3 to every digit of five or more before the shift
  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      bcd_adj[i] = (bcd_r[i] >= BCD_ADJ_MIN) ? bcd_r[i] + BCD_ADJ : bcd_r[i];
    end
  end

  // highest nonzero digit; zero prints one digit
  always_comb begin
    lead = '0;
    for (int i = 0; i < DIGITS; i++) begin
      if (bcd_r[i] != '0) lead = IDX_W'(i);
    end
  end

  always_comb begin
    take = 1'b0;
    unique case (state_r)
      ST_IDLE:  take = 1'b1;
      ST_DIGIT: take = out_free && (idx_r == '0);
      default:  take = 1'b0;
    endcase
  end
  assign pop_ready = take;

  always_comb begin
    state_nxt     = state_r;
    neg_nxt       = neg_r;
    bin_nxt       = bin_r;
    bcd_nxt       = bcd_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    if (out_ch.ready) out_valid_nxt = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        // wait for a job
      end
      ST_CONV: begin
        // shift the adjusted digits left by one, bringing in the next magnitude bit;
        // the top bit that falls out is always zero for a 32-bit magnitude
        bcd_nxt = {bcd_adj[DIGITS-1][DIGIT_W-2:0], bcd_adj[DIGITS-2:0], bin_r[VALUE_W-1]};
        bin_nxt = bin_r << 1;
        cnt_nxt = cnt_r + STEP_W'(1);
        if (cnt_r == STEP_W'(VALUE_W - 1)) state_nxt = ST_LEAD;
      end
      ST_LEAD: begin
        idx_nxt   = lead;
        state_nxt = neg_r ? ST_SIGN : ST_DIGIT;
      end
      ST_SIGN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = ASCII_MINUS;
          out_last_nxt  = 1'b0;
          state_nxt     = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = ASCII_ZERO + CHAR_W'(bcd_r[idx_r]);
          out_last_nxt  = (idx_r == '0);
          if (idx_r == '0) state_nxt = ST_IDLE;
          else             idx_nxt   = idx_r - IDX_W'(1);
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    // load the next job; also overlaps the last digit of the previous one
    if (take && pop_valid) begin
      neg_nxt   = pop_job.neg;
      bin_nxt   = pop_job.mag;
      bcd_nxt   = '0;
      cnt_nxt   = '0;
      state_nxt = ST_CONV;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    neg_r      <= neg_nxt;
    bin_r      <= bin_nxt;
    bcd_r      <= bcd_nxt;
    cnt_r      <= cnt_nxt;
    idx_r      <= idx_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule

/* sv/signed_int_to_decimal_ascii.sv */
// Signed 32-bit integer to decimal ASCII text, most significant digit first.
// Path: front stage register, then job queue, then the back end, which runs 32 shift
//   steps, finds the leading digit and emits one output beat per character.
// The back end converts one number at a time with the shift-add-3 loop; later numbers
//   wait in the queue, and the last digit overlaps the next job load.
// Reset: synchronous, active low; clears handshake and sequencer state only.
module signed_int_to_decimal_ascii #(
  parameter int QUEUE_DEPTH = sitda_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  sitda_in_if.sink    in_ch,
  sitda_out_if.source out_ch
);
  import sitda_pkg::*;

  // Front stage to queue
  logic push_valid, push_ready;
  job_t push_job;
  // Queue to back end
  logic pop_valid, pop_ready;
  job_t pop_job;

  // Classify: sign flag plus unsigned magnitude, held in one stage register.
  sitda_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job)
  );

  // Decouple intake from the long conversion so new numbers can queue up.
  sitda_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_job    (pop_job)
  );

  // Convert to BCD and stream characters through a registered output beat.
  sitda_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_job   (pop_job),
    .out_ch    (out_ch)
  );

  // A minus sign never ends a number.
  a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.char_code == ASCII_MINUS) |-> !out_ch.is_last)
    else $error("minus sign flagged as last character");

  // Output beats are only ever a minus sign or a decimal digit.
  a_char_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.char_code == ASCII_MINUS ||
                      (out_ch.char_code >= ASCII_ZERO &&
                       out_ch.char_code <= ASCII_ZERO + CHAR_W'(9))))
    else $error("illegal output character");

  // No output beat is pending right after reset.
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("output valid after reset");

  // A full queue with a waiting front stage must stall the input.
  a_stall_on_full: assert property (@(posedge clk) disable iff (!rst_n)
    (push_valid && !push_ready) |-> !in_ch.ready)
    else $error("input accepted while queue full");

endmodule

/* sim/tb_signed_int_to_decimal_ascii.sv */
`timescale 1ns / 100ps
// Self-checking testbench for signed_int_to_decimal_ascii: integers in, decimal ASCII beats out.
// Depends on sitda_pkg, sitda_if (sitda_in_if, sitda_out_if) and the block itself.
module tb_signed_int_to_decimal_ascii;
  import sitda_pkg::*;

  localparam int DECIMAL_BASE = 10;
  localparam int RESET_CYCLES = 6;
  localparam int DRAIN_CYCLES = 60;    // a little over one full conversion
  localparam int HOLD_CYCLES  = 400;   // long receiver hold-off, fills the job queue
  localparam int IDLE_LIMIT   = 3000;  // cycles with no beat on either side

  // One expected output character.
  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              last;
  } char_beat_t;

  logic clk;
  logic rst_n;

  sitda_in_if  in_ch ();
  sitda_out_if out_ch ();

  signed_int_to_decimal_ascii u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  logic signed [VALUE_W-1:0] pending_values[$];   // numbers still to be offered
  char_beat_t                expected_chars[$];   // characters still owed by the block
  char_beat_t                oldest_char;

  int send_idle_pct;
  int recv_idle_pct;
  int hold_off_req;
  int hold_off_ack;
  int hold_left;
  int idle_cycles;
  int error_count;

  // 4 ns clock.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Print one mismatch line and count it.
  task automatic report_mismatch(input string what);
    error_count++;
    $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  // Decimal text of one integer: optional minus, then digits MSB first, last flag on the end.
  function automatic void predict_decimal_text(input logic signed [VALUE_W-1:0] value);
    logic [VALUE_W-1:0] raw;
    logic [VALUE_W-1:0] mag;
    logic [CHAR_W-1:0]  digit_codes[DIGITS];
    int                 n;
    raw = value;
    // Magnitude as unsigned, so the most negative value needs no special path.
    mag = raw[VALUE_W-1] ? (~raw + 1'b1) : raw;
    n   = 0;
    // Least significant digit first; zero still gives one digit.
    do begin
      digit_codes[n] = ASCII_ZERO + CHAR_W'(mag % DECIMAL_BASE);
      mag            = mag / DECIMAL_BASE;
      n++;
    end while (mag != 0);
    if (raw[VALUE_W-1])
      expected_chars.push_back('{code: ASCII_MINUS, last: 1'b0});
    for (int i = n - 1; i >= 0; i--)
      expected_chars.push_back('{code: digit_codes[i], last: (i == 0)});
  endfunction

  // Random number: full-range bits, chosen digit counts, small values, near powers of ten or the extremes.
  function automatic logic signed [VALUE_W-1:0] random_value();
    longint lo;
    longint hi;
    longint v;
    int     len;
    lo = 1;
    v  = 0;
    case ($urandom_range(3))
      0: v = longint'($urandom);
      1: begin
        len = $urandom_range(1, DIGITS);
        repeat (len - 1) lo = lo * DECIMAL_BASE;
        hi = lo * DECIMAL_BASE - 1;
        if (hi > 64'sd2147483647) hi = 64'sd2147483647;
        if (len == 1) lo = 0;
        v = lo + longint'($urandom) % (hi - lo + 1);
        if ($urandom_range(1)) v = -v;
      end
      2: begin
        v = $urandom_range(999);
        if ($urandom_range(1)) v = -v;
      end
      default: begin
        if ($urandom_range(7) == 0) begin
          v = $urandom_range(1) ? 64'sd2147483647 : -64'sd2147483648;
        end else begin
          repeat ($urandom_range(DIGITS - 1)) lo = lo * DECIMAL_BASE;
          v = lo + $urandom_range(2) - 1;
          if ($urandom_range(1)) v = -v;
        end
      end
    endcase
    return VALUE_W'(v);
  endfunction

  // Driver: hold the offered number until it is taken, predict its text on acceptance,
  // then offer the next one unless this cycle is an idle one.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready)
        predict_decimal_text(in_ch.value);
      if (in_ch.valid && !in_ch.ready) begin
        // hold: the beat is still on offer
      end else if (pending_values.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_ch.valid <= 1'b1;
        in_ch.value <= pending_values.pop_front();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Monitor: check every character beat against the oldest expectation, then pick the
  // next ready. A hold-off request drops ready for a long stretch counted here.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      hold_left    <= 0;
      hold_off_ack <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_chars.size() == 0) begin
          report_mismatch($sformatf("unexpected char 0x%02h last=%0b",
                                    out_ch.char_code, out_ch.is_last));
        end else begin
          oldest_char = expected_chars.pop_front();
          if (out_ch.char_code !== oldest_char.code)
            report_mismatch($sformatf("char_code 0x%02h, expected 0x%02h",
                                      out_ch.char_code, oldest_char.code));
          if (out_ch.is_last !== oldest_char.last)
            report_mismatch($sformatf("is_last %0b, expected %0b on char 0x%02h",
                                      out_ch.is_last, oldest_char.last, oldest_char.code));
        end
      end
      if (hold_off_ack != hold_off_req) begin
        hold_off_ack <= hold_off_req;
        hold_left    <= HOLD_CYCLES;
        out_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left    <= hold_left - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog: end the run if neither side moves a beat for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Queue a batch of random numbers under one idle mix and wait for every character.
  task automatic run_phase(input int s_idle, input int r_idle, input int n_items,
                           input bit hold_off);
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    if (hold_off)
      hold_off_req++;
    repeat (n_items) pending_values.push_back(random_value());
    while (pending_values.size() != 0 || in_ch.valid || expected_chars.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    clk           = 1'b0;
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.value   = '0;
    out_ch.ready  = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_off_req  = 0;
    idle_cycles   = 0;
    error_count   = 0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: zero, single digits, the 1/2 and 9/10 digit count boundaries, both extremes,
    // and the most negative value whose magnitude only fits unsigned.
    pending_values.push_back(0);
    pending_values.push_back(1);
    pending_values.push_back(-1);
    pending_values.push_back(9);
    pending_values.push_back(10);
    pending_values.push_back(-10);
    pending_values.push_back(42);
    pending_values.push_back(100);
    pending_values.push_back(-999);
    pending_values.push_back(12345);
    pending_values.push_back(-1234567);
    pending_values.push_back(999999999);
    pending_values.push_back(-999999999);
    pending_values.push_back(1000000000);
    pending_values.push_back(-1000000000);
    pending_values.push_back(1999999999);
    pending_values.push_back(32'sh7FFFFFFF);
    pending_values.push_back(32'sh80000000);
    pending_values.push_back(32'sh80000001);
    pending_values.push_back(32'sh55555555);
    pending_values.push_back(32'shAAAAAAAA);

    // Slow sender with a slow receiver, then the reverse, then full rate with one
    // long receiver hold-off so the block backs up into its input.
    run_phase(25, 60, 90, 1'b0);
    run_phase(60, 25, 100, 1'b0);
    run_phase(0, 0, 100, 1'b1);

    if (expected_chars.size() != 0)
      report_mismatch($sformatf("%0d characters never arrived", expected_chars.size()));

    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
